@@ hdl/elfh_pkg.sv @@
// ----------------------------------------------------------------------------
// ELF hash package
// Widths, final mix shift tables and the byte absorb and mix stage functions.
// ----------------------------------------------------------------------------
package elfh_pkg;

    localparam int BYTE_W = 8;
    localparam int HASH_W = 28;
    localparam int OUT_W = 32;
    localparam int NIB_W = OUT_W - HASH_W;

    localparam int MIX_STAGES = 4;
    localparam int MIX_ADD_SH [MIX_STAGES] = '{16, 4, 10, 8};
    localparam int MIX_XOR_SH [MIX_STAGES] = '{13, 7, 5, 16};

    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 2;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [OUT_W-1:0] word_t;

    function automatic hash_t absorb_byte(hash_t h, logic [BYTE_W-1:0] b);
        word_t t;
        logic [NIB_W-1:0] top;
        t = {h, {NIB_W{1'b0}}} + {{(OUT_W-BYTE_W){1'b0}}, b};
        top = t[OUT_W-1:HASH_W];
        return t[HASH_W-1:0] ^ {{(HASH_W-2*NIB_W){1'b0}}, top, {NIB_W{1'b0}}};
    endfunction

    function automatic word_t mix_stage(word_t r, int unsigned k);
        word_t s;
        s = r + (r << MIX_ADD_SH[k]);
        return s ^ (s >> MIX_XOR_SH[k]);
    endfunction

endpackage

@@ hdl/elfh_fifo.sv @@
// ----------------------------------------------------------------------------
// ELF hash word queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module elfh_fifo
    import elfh_pkg::*;
#(
    parameter int WIDTH = OUT_W,
    parameter int DEPTH = OUT_DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign dout = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("Queue count exceeds its depth.");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (empty || full) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("Queue pointers disagree with the count.");

endmodule

@@ hdl/elfh_front.sv @@
// ----------------------------------------------------------------------------
// ELF hash front end
// Accepts words, absorbs message bytes and hands finished hashes onward.
// ----------------------------------------------------------------------------
module elfh_front
    import elfh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              byte_present,
    input  logic              last,
    output logic              mid_push,
    output hash_t             mid_hash
);

    hash_t running_hash_reg;
    hash_t running_hash_next;

    always_comb
    begin
        mid_hash = byte_present ? absorb_byte(running_hash_reg, data_byte)
                                : running_hash_reg;
        mid_push = accept && last;
        running_hash_next = running_hash_reg;
        if (accept)
        begin
            running_hash_next = last ? '0 : mid_hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= '0;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (running_hash_reg == '0))
        else $error("Running hash not cleared after the end of a message.");

endmodule

@@ hdl/elfh_mix.sv @@
// ----------------------------------------------------------------------------
// ELF hash final mix
// Four-stage add-shift and xor-shift pipeline feeding the result queue.
// ----------------------------------------------------------------------------
module elfh_mix
    import elfh_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  hash_t       in_hash,
    output logic        in_take,
    input  logic        pop,
    output logic        empty,
    output logic [OUT_W-1:0] hash_value
);

    logic  stage_valid_reg [MIX_STAGES];
    word_t stage_data_reg [MIX_STAGES];
    logic  advance;
    logic  out_full;
    logic  out_push;

    assign advance = !(stage_valid_reg[MIX_STAGES-1] && out_full);
    assign in_take = advance && in_valid;
    assign out_push = advance && stage_valid_reg[MIX_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MIX_STAGES; k++)
            begin
                stage_valid_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            stage_valid_reg[0] <= in_valid;
            for (int k = 1; k < MIX_STAGES; k++)
            begin
                stage_valid_reg[k] <= stage_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_data_reg[0] <= mix_stage({{NIB_W{1'b0}}, in_hash}, 0);
            for (int k = 1; k < MIX_STAGES; k++)
            begin
                stage_data_reg[k] <= mix_stage(stage_data_reg[k-1], k);
            end
        end
    end

    elfh_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .din   (stage_data_reg[MIX_STAGES-1]),
        .full  (out_full),
        .pop   (pop),
        .dout  (hash_value),
        .empty (empty)
    );

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(stage_data_reg[MIX_STAGES-1]))
        else $error("Last mix stage changed while stalled.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("Result pushed into a full queue.");

endmodule

@@ hdl/elfh_hash_with_final_mix_unit.sv @@
// ----------------------------------------------------------------------------
// ELF hash with final mix unit
// Byte-serial ELF hash with a pipelined 32-bit final mix.
// ----------------------------------------------------------------------------
// Input words are pushed with push while full is low; each word carries an
// optional message byte and an end-of-message flag. Results come out of a
// queue: hash_value is valid while empty is low and is taken with pop.
// The front end absorbs one byte per cycle, so one word is accepted every
// cycle while full is low. A word with last set moves the running hash into
// a short queue and clears it for the next message. The back end runs the
// final mix in a four-stage pipeline, one add and one xor-shift per stage,
// and writes the result queue. Results can be taken one per cycle.
// When the receiver stops popping, the result queue and then the mix
// pipeline fill; full rises once the hash queue between front and back
// has no free entry. Reset clears the running hash and empties both queues.
// ----------------------------------------------------------------------------
module elf_hash_with_final_mix_unit
    import elfh_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              byte_present,
    input  logic              last,
    input  logic              pop,
    output logic              empty,
    output logic [OUT_W-1:0]  hash_value
);

    logic  accept;
    logic  mid_push;
    hash_t mid_hash;
    logic  mid_full;
    logic  mid_empty;
    hash_t mid_dout;
    logic  mid_take;

    assign full = mid_full;
    assign accept = push && !mid_full;

    elfh_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last         (last),
        .mid_push     (mid_push),
        .mid_hash     (mid_hash)
    );

    elfh_fifo #(
        .WIDTH (HASH_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (mid_push),
        .din   (mid_hash),
        .full  (mid_full),
        .pop   (mid_take),
        .dout  (mid_dout),
        .empty (mid_empty)
    );

    elfh_mix #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (!mid_empty),
        .in_hash    (mid_dout),
        .in_take    (mid_take),
        .pop        (pop),
        .empty      (empty),
        .hash_value (hash_value)
    );

endmodule

@@ dv/elf_hash_with_final_mix_unit_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ELF hash with final mix checker
// Watches the word and result queues of the hash unit, keeps its own running
// hash for every accepted word and compares each popped hash with the oldest
// predicted one.
// ----------------------------------------------------------------------------
module elf_hash_with_final_mix_unit_checker
    import elfh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              byte_present,
    input  logic              last,
    input  logic              pop,
    input  logic              empty,
    input  logic [OUT_W-1:0]  hash_value,
    output int                errors,
    output int                pending,
    output int                checked
);

    logic [HASH_W-1:0] msg_hash;
    logic [OUT_W-1:0]  hash_expected [$];
    int                err_count;
    int                hash_count;

    function automatic logic [HASH_W-1:0] fold_byte(logic [HASH_W-1:0] h,
                                                    logic [BYTE_W-1:0] b);
        logic [OUT_W-1:0] t;
        logic [3:0]       top;
        t = {h, 4'h0} + {24'h0, b};
        top = t[31:28];
        t[7:4] = t[7:4] ^ top;
        return t[HASH_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] mix_hash(logic [OUT_W-1:0] r);
        r = r + (r << 16);
        r = r ^ (r >> 13);
        r = r + (r << 4);
        r = r ^ (r >> 7);
        r = r + (r << 10);
        r = r ^ (r >> 5);
        r = r + (r << 8);
        r = r ^ (r >> 16);
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [OUT_W-1:0] exp_val,
                                 input logic [OUT_W-1:0] act_val);
        err_count++;
        if (err_count <= 10)
        begin
            $display("%0t: %s hash_value: expected %08h, got %08h", $realtime, what,
                     exp_val, act_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [OUT_W-1:0] exp_val;
        if (!rst_n)
        begin
            msg_hash = '0;
            hash_expected.delete();
            err_count = 0;
            hash_count = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (hash_expected.size() == 0)
                begin
                    note_mismatch("unexpected word", '0, hash_value);
                end
                else
                begin
                    exp_val = hash_expected.pop_front();
                    hash_count++;
                    if (hash_value !== exp_val)
                        note_mismatch("wrong", exp_val, hash_value);
                end
            end
            if (push && !full)
            begin
                if (byte_present)
                    msg_hash = fold_byte(msg_hash, data_byte);
                if (last)
                begin
                    hash_expected.push_back(mix_hash({4'h0, msg_hash}));
                    msg_hash = '0;
                end
            end
        end
        errors <= err_count;
        pending <= hash_expected.size();
        checked <= hash_count;
    end

endmodule

@@ dv/elf_hash_with_final_mix_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ELF hash with final mix testbench
// Sends directed and random byte messages to the hash unit under four idling
// patterns on the word and result queues; a separate checker predicts and
// compares every hash.
// ----------------------------------------------------------------------------
module elf_hash_with_final_mix_unit_tb;
    import elfh_pkg::*;

    localparam int MAX_CYCLES = 200000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] data_byte = '0;
    logic              byte_present = 1'b0;
    logic              last = 1'b0;
    logic              pop = 1'b0;
    logic              empty;
    logic [OUT_W-1:0]  hash_value;

    int errors;
    int pending;
    int checked;
    int cycle_count = 0;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;
    int words_sent = 0;
    int messages_sent = 0;

    always #6 clk = ~clk;

    elf_hash_with_final_mix_unit DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last         (last),
        .pop          (pop),
        .empty        (empty),
        .hash_value   (hash_value)
    );

    elf_hash_with_final_mix_unit_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .last         (last),
        .pop          (pop),
        .empty        (empty),
        .hash_value   (hash_value),
        .errors       (errors),
        .pending      (pending),
        .checked      (checked)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("Timed out after %0d cycles with %0d hashes outstanding.",
                     cycle_count, pending);
            $display("[elf_hash_with_final_mix_unit] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        pop <= ($urandom_range(0, 99) >= pop_stall_pct);
    end

    task automatic send_word(input logic [BYTE_W-1:0] b, input logic present,
                             input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        data_byte <= b;
        byte_present <= present;
        last <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (present || fin)
            words_sent++;
        if (fin)
            messages_sent++;
    endtask

    task automatic send_message(input int len, input bit separate_last, input int noise_pct);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_word($urandom_range(0, 255), 1'b0, 1'b0);
            send_word($urandom_range(0, 255), 1'b1, (i == len - 1) && !separate_last);
        end
        if (separate_last || len == 0)
            send_word($urandom_range(0, 255), 1'b0, 1'b1);
    endtask

    initial
    begin
        int idle_table [4];
        int stall_table [4];
        int target;
        int len;
        int pick;
        idle_table = '{0, 84, 0, 23};
        stall_table = '{0, 0, 84, 23};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty messages, an idle word between them, and single-byte extremes.
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h01, 1'b0, 1'b1);
        // All-ones bytes push the running hash into its top nibble and fold it back.
        for (int i = 0; i < 9; i++)
            send_word(8'hFF, 1'b1, i == 8);
        send_word(8'hAA, 1'b1, 1'b0);
        send_word(8'h33, 1'b0, 1'b0);
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'hC3, 1'b0, 1'b1);

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = idle_table[phase];
            pop_stall_pct = stall_table[phase];
            target = words_sent + 170;
            while (words_sent < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    len = 0;
                else if (pick < 82)
                    len = $urandom_range(1, 8);
                else
                    len = $urandom_range(9, 40);
                send_message(len, $urandom_range(0, 1), 10);
            end
        end

        push <= 1'b0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d messages in %0d words under four idling patterns.",
                 messages_sent, words_sent);
        $display("Checked %0d hashes, %0d mismatches.", checked, errors);
        if (errors == 0 && pending == 0)
        begin
            $display("[elf_hash_with_final_mix_unit] OK");
        end
        else
        begin
            $display("[elf_hash_with_final_mix_unit] ERROR");
        end
        $finish;
    end

endmodule
